[design/ffo_pkg.sv]
// shared widths, limits and fixed-point constants of the feedback fm oscillator
`timescale 1ns / 1ps
package ffo_pkg;

  // field widths
  localparam int AMP_W   = 16;
  localparam int FREQ_W  = 24;
  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 20;
  localparam int SMP_W   = 16;
  localparam int PHASE_W = 32;

  // first operand of the shared multiplier holds any frequency term, sign included
  localparam int MUL_A_W = FREQ_W + 1;

  // reset value of the phase step register
  localparam logic [STEP_W-1:0] STEP_RESET = 20'd97391;

  // saturation limits
  localparam logic signed [FREQ_W-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [FREQ_W-1:0] S24_MIN = -24'sh800000;
  localparam logic signed [SMP_W-1:0]  S16_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0]  S16_MIN = -16'sh8000;

  // q30 constants for building the cosine table
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

endpackage

[design/ffo_mul.sv]
// shared signed multiplier with registered product
`timescale 1ns / 1ps
module ffo_mul #(
  parameter int MUL_B_W = 23
) (
  input  logic                                     clk,
  input  logic signed [ffo_pkg::MUL_A_W-1:0]         op_a,
  input  logic signed [MUL_B_W-1:0]                  op_b,
  output logic signed [ffo_pkg::MUL_A_W+MUL_B_W-1:0] prod
);
  import ffo_pkg::*;

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

[design/ffo_rom.sv]
// cosine table over one full period with registered read
`timescale 1ns / 1ps
module ffo_rom #(
  parameter int TABLE_SIZE = 1024,
  localparam int ADDR_W = $clog2(TABLE_SIZE + 1)
) (
  input  logic                              clk,
  input  logic [ADDR_W-1:0]                 addr,
  output logic signed [ffo_pkg::SMP_W-1:0]  rd_data
);
  import ffo_pkg::*;

  // round(32767 * cos(2 pi n / size)) by a folded q30 taylor series
  function automatic logic signed [SMP_W-1:0] rom_value(input int unsigned n);
    longint m;
    longint x;
    longint x2;
    longint r;
    longint t;
    longint v;
    logic   neg;
    m   = longint'(n % TABLE_SIZE);
    neg = 1'b0;
    if (2 * m > TABLE_SIZE) m = TABLE_SIZE - m;
    x = (TWO_PI_Q30 * m) / TABLE_SIZE;
    if (x > HALF_PI_Q30) begin
      x   = PI_Q30 - x;
      neg = 1'b1;
    end
    x2 = (x * x) >>> 30;
    r  = Q30_ONE;
    // horner steps, divisors 14*13 down to 2*1
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 182; if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 132; if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 90;  if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 56;  if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 30;  if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 12;  if (r < 0) r = 0;
    t = (x2 * r) >>> 30; r = Q30_ONE - t / 2;   if (r < 0) r = 0;
    v = (r * 64'sd32767 + 64'sd536870912) >>> 30;
    if (neg) v = -v;
    return v[SMP_W-1:0];
  endfunction

  logic signed [SMP_W-1:0] tbl [0:TABLE_SIZE];

  // constant entries, one past the period for interpolation
  for (genvar n = 0; n <= TABLE_SIZE; n++) begin : g_entry
    assign tbl[n] = rom_value(n);
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= tbl[addr];
  end

endmodule

[design/feedback_fm_oscillator.sv]
// feedback fm oscillator: sequencer around one shared multiplier and the cosine table
// one input word in work at a time: a new word is taken only after the last result
// is loaded; eight products go one after another through the single multiplier,
// and the two table reads share the one rom port
// reset: phase and feedback term cleared, phase step set to 97391; the table is
// constant, so there is no clearing pass
`timescale 1ns / 1ps
module feedback_fm_oscillator #(
  parameter int TABLE_SIZE    = 1024,
  parameter int FRACTION_BITS = 22
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ffo_pkg::AMP_W-1:0]    amplitude,
  input  logic signed [ffo_pkg::FREQ_W-1:0]   base_frequency,
  input  logic signed [ffo_pkg::FREQ_W-1:0]   modulation,
  input  logic signed [ffo_pkg::GAIN_W-1:0]   feedback_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ffo_pkg::SMP_W-1:0]    sample,
  output logic signed [ffo_pkg::FREQ_W-1:0]   modulator_out,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffo_pkg::STEP_W-1:0]          cfg_data
);
  import ffo_pkg::*;

  localparam int HI_W    = PHASE_W - FRACTION_BITS;
  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int ADDR_W  = $clog2(TABLE_SIZE + 1);
  localparam int R_W     = ((HI_W > IDX_W) ? HI_W : IDX_W) + 1;
  localparam int MUL_B_W = (FRACTION_BITS + 1 > STEP_W + 1) ? FRACTION_BITS + 1 : STEP_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  // reciprocal for the table index modulo, quotient low by at most one
  localparam int MOD_M   = (1 << HI_W) / TABLE_SIZE;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FBG  = 4'd1;
  localparam logic [3:0] S_MODQ = 4'd2;
  localparam logic [3:0] S_MODR = 4'd3;
  localparam logic [3:0] S_IDX  = 4'd4;
  localparam logic [3:0] S_RD0  = 4'd5;
  localparam logic [3:0] S_RD1  = 4'd6;
  localparam logic [3:0] S_DIF  = 4'd7;
  localparam logic [3:0] S_CV   = 4'd8;
  localparam logic [3:0] S_CF   = 4'd9;
  localparam logic [3:0] S_CA   = 4'd10;
  localparam logic [3:0] S_FA   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]                state;
  logic [3:0]                state_next;
  logic [PHASE_W-1:0]        phase;
  logic signed [FREQ_W-1:0]  feedback_term;
  logic [STEP_W-1:0]         step;

  logic signed [AMP_W-1:0]   amp_q;
  logic signed [FREQ_W-1:0]  base_q;
  logic signed [FREQ_W-1:0]  mod_q;
  logic signed [GAIN_W-1:0]  gain_q;
  logic signed [FREQ_W-1:0]  freq;
  logic [IDX_W-1:0]          idx;
  logic [PHASE_W-1:0]        inc;
  logic signed [SMP_W-1:0]   c0;
  logic signed [SMP_W:0]     cval;
  logic signed [SMP_W-1:0]   smp;
  logic signed [SMP_W-1:0]   sample_q;
  logic signed [FREQ_W-1:0]  mod_out_q;
  logic                      out_valid_q;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]         rom_addr;
  logic signed [SMP_W-1:0]   rom_data;

  logic [HI_W-1:0]           hi;
  logic [FRACTION_BITS-1:0]  frac;
  logic [HI_W-1:0]           quot;
  logic [R_W-1:0]            rem_raw;
  logic [R_W-1:0]            rem_fix;
  logic signed [PROD_W-1:0]  f_sum;
  logic signed [PROD_W-1:0]  inc_adj;
  logic signed [PROD_W-1:0]  c_sum;
  logic signed [PROD_W-1:0]  prod_s15;
  logic signed [SMP_W:0]     diff;
  logic                      in_acc;
  logic                      out_load;

  // clamp helpers
  function automatic logic signed [FREQ_W-1:0] sat24(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(S24_MAX)) return S24_MAX;
    if (v < PROD_W'(S24_MIN)) return S24_MIN;
    return v[FREQ_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(S16_MAX)) return S16_MAX;
    if (v < PROD_W'(S16_MIN)) return S16_MIN;
    return v[SMP_W-1:0];
  endfunction

  ffo_mul #(
    .MUL_B_W (MUL_B_W)
  ) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  ffo_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk     (clk),
    .addr    (rom_addr),
    .rd_data (rom_data)
  );

  // handshakes
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid_q || out_ready);
  assign cfg_ready = 1'b1;
  assign out_valid     = out_valid_q;
  assign sample        = sample_q;
  assign modulator_out = mod_out_q;

  // phase split and derived terms from the registered product
  assign hi       = phase[PHASE_W-1:FRACTION_BITS];
  assign frac     = phase[FRACTION_BITS-1:0];
  assign quot     = prod[HI_W +: HI_W];
  assign rem_raw  = R_W'(hi) - prod[R_W-1:0];
  assign rem_fix  = (rem_raw >= R_W'(TABLE_SIZE)) ? rem_raw - R_W'(TABLE_SIZE) : rem_raw;
  assign f_sum    = PROD_W'(base_q) + PROD_W'(mod_q) + (prod >>> 12);
  assign inc_adj  = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
  assign c_sum    = PROD_W'(c0) + (prod >>> FRACTION_BITS);
  assign prod_s15 = prod >>> 15;
  assign diff     = {rom_data[SMP_W-1], rom_data} - {c0[SMP_W-1], c0};

  // table address: lower entry, then upper entry
  assign rom_addr = (state == S_RD1) ? ADDR_W'(idx) + ADDR_W'(1) : ADDR_W'(idx);

  // multiplier operand selection
  always_comb begin
    case (state)
      S_FBG: begin
        op_a = MUL_A_W'(feedback_term);
        op_b = MUL_B_W'(gain_q);
      end
      S_MODQ: begin
        op_a = MUL_A_W'({1'b0, hi});
        op_b = MUL_B_W'(MOD_M);
      end
      S_MODR: begin
        op_a = MUL_A_W'({1'b0, quot});
        op_b = MUL_B_W'(TABLE_SIZE);
      end
      S_IDX: begin
        op_a = MUL_A_W'(freq);
        op_b = MUL_B_W'({1'b0, step});
      end
      S_DIF: begin
        op_a = MUL_A_W'(diff);
        op_b = MUL_B_W'({1'b0, frac});
      end
      S_CF: begin
        op_a = MUL_A_W'(freq);
        op_b = MUL_B_W'(cval);
      end
      S_CA: begin
        op_a = MUL_A_W'(cval);
        op_b = MUL_B_W'(amp_q);
      end
      S_FA, S_DONE: begin
        op_a = MUL_A_W'(feedback_term);
        op_b = MUL_B_W'(amp_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    case (state)
      S_IDLE:  state_next = in_acc ? S_FBG : S_IDLE;
      S_FBG:   state_next = S_MODQ;
      S_MODQ:  state_next = S_MODR;
      S_MODR:  state_next = S_IDX;
      S_IDX:   state_next = S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_DIF;
      S_DIF:   state_next = S_CV;
      S_CV:    state_next = S_CF;
      S_CF:    state_next = S_CA;
      S_CA:    state_next = S_FA;
      S_FA:    state_next = S_DONE;
      S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= '0;
      feedback_term <= '0;
      step          <= STEP_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) step <= cfg_data;
      if (state == S_CA) feedback_term <= sat24(prod_s15);
      if (out_load) begin
        phase       <= phase + inc;
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      amp_q  <= amplitude;
      base_q <= base_frequency;
      mod_q  <= modulation;
      gain_q <= feedback_gain;
    end
    if (state == S_MODQ) freq <= sat24(f_sum);
    if (state == S_IDX)  idx  <= rem_fix[IDX_W-1:0];
    if (state == S_RD0)  inc  <= inc_adj[8 +: PHASE_W];
    if (state == S_RD1)  c0   <= rom_data;
    if (state == S_CV)   cval <= c_sum[SMP_W:0];
    if (state == S_FA)   smp  <= sat16(prod_s15);
    if (out_load) begin
      sample_q  <= smp;
      mod_out_q <= sat24(prod_s15);
    end
  end

  // a new word is never taken while one is in work
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in work");

  // phase moves only when a result word is loaded
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !out_load |=> $stable(phase))
    else $error("phase changed without a result");

  // a result appears only out of the final sequencer step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result valid without finishing an item");

endmodule

[tb/tb_top.sv]
// self-checking testbench for the feedback fm oscillator with its own bit-exact predictor
`timescale 1ns / 1ps
module tb_top;
  import ffo_pkg::*;

  localparam int TBL        = 1024;
  localparam int FRAC_BITS  = 22;
  localparam int SETTLE_CYC = 24;
  localparam int LONG_HOLD  = 300;

  typedef struct {
    logic signed [AMP_W-1:0]  amp;
    logic signed [FREQ_W-1:0] base_freq;
    logic signed [FREQ_W-1:0] fm;
    logic signed [GAIN_W-1:0] gain;
  } osc_word_t;

  typedef struct {
    logic signed [SMP_W-1:0]  smp;
    logic signed [FREQ_W-1:0] mod_out;
  } osc_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [AMP_W-1:0]  amplitude = '0;
  logic signed [FREQ_W-1:0] base_frequency = '0;
  logic signed [FREQ_W-1:0] modulation = '0;
  logic signed [GAIN_W-1:0] feedback_gain = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SMP_W-1:0]  sample;
  logic signed [FREQ_W-1:0] modulator_out;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [STEP_W-1:0]        cfg_data = '0;

  // predictor state
  longint            cos_table [0:TBL];
  logic [PHASE_W-1:0] osc_phase = '0;
  longint            fb_term = 0;
  logic [STEP_W-1:0] step_reg = STEP_RESET;

  osc_word_t pending_words[$];
  osc_out_t  expected_samples[$];
  osc_word_t cur_word;

  int fail_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_req = 0;
  int hold_served = 0;
  bit no_idle = 1'b0;

  feedback_fm_oscillator uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .amplitude      (amplitude),
    .base_frequency (base_frequency),
    .modulation     (modulation),
    .feedback_gain  (feedback_gain),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .modulator_out  (modulator_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // q30 taylor evaluation of one table entry, folded into the first quadrant
  function automatic longint cos_entry(int n);
    longint m, x, x2, r, t, v;
    bit neg;
    neg = 1'b0;
    m = n % TBL;
    if (2 * m > TBL) m = TBL - m;
    x = (TWO_PI_Q30 * m) / TBL;
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
      neg = 1'b1;
    end
    x2 = (x * x) >> 30;
    r = Q30_ONE;
    for (int k = 7; k >= 1; k--) begin
      t = (x2 * r) >> 30;
      r = Q30_ONE - t / ((2 * k) * (2 * k - 1));
      if (r < 0) r = 0;
    end
    v = (r * 32767 + (64'sd1 << 29)) >> 30;
    return neg ? -v : v;
  endfunction

  // one oscillator step: frequency, interpolated cosine, phase and feedback update
  function automatic osc_out_t oscillate(osc_word_t w);
    longint a, g, f, c, d, frac, inc, md, smp;
    int unsigned idx;
    osc_out_t r;
    a = w.amp;
    g = w.gain;
    f = sat(longint'(w.base_freq) + longint'(w.fm) + ((fb_term * g) >>> 12),
            S24_MIN, S24_MAX);
    idx = (osc_phase >> FRAC_BITS) % TBL;
    frac = longint'(osc_phase[FRAC_BITS-1:0]);
    d = cos_table[idx + 1] - cos_table[idx];
    c = cos_table[idx] + ((d * frac) >>> FRAC_BITS);
    inc = (f * longint'(step_reg)) / 256;
    osc_phase = osc_phase + inc[PHASE_W-1:0];
    fb_term = sat((c * f) >>> 15, S24_MIN, S24_MAX);
    md = sat((fb_term * a) >>> 15, S24_MIN, S24_MAX);
    smp = sat((a * c) >>> 15, S16_MIN, S16_MAX);
    r.smp = smp[SMP_W-1:0];
    r.mod_out = md[FREQ_W-1:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 15);
    return $urandom_range(16, 60);
  endfunction

  // audio-like words most of the time, raw bit noise otherwise
  function automatic osc_word_t rand_word();
    osc_word_t w;
    int v;
    w.amp = AMP_W'($urandom);
    if ($urandom_range(0, 9) < 3) begin
      w.base_freq = FREQ_W'($urandom);
      w.fm = FREQ_W'($urandom);
      w.gain = GAIN_W'($urandom);
    end else begin
      v = $urandom_range(0, 20000 * 256);
      if ($urandom_range(0, 3) == 0) v = -v;
      w.base_freq = v[FREQ_W-1:0];
      v = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 1024000)) - 512000;
      w.fm = v[FREQ_W-1:0];
      v = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16384)) - 8192;
      w.gain = v[GAIN_W-1:0];
    end
    return w;
  endfunction

  task automatic push_word(int a, int bf, int m, int g);
    osc_word_t w;
    w.amp = a[AMP_W-1:0];
    w.base_freq = bf[FREQ_W-1:0];
    w.fm = m[FREQ_W-1:0];
    w.gain = g[GAIN_W-1:0];
    pending_words.push_back(w);
  endtask

  task automatic push_random(int n);
    repeat (n) pending_words.push_back(rand_word());
  endtask

  // waits until every queued word is sent and every predicted word has come back, checked between edges
  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_reg = v;
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_samples.push_back(oscillate(cur_word));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur_word = pending_words.pop_front();
          amplitude <= cur_word.amp;
          base_frequency <= cur_word.base_freq;
          modulation <= cur_word.fm;
          feedback_gain <= cur_word.gain;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    osc_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("output word with no prediction waiting");
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.smp) begin
            $error("sample: expected %0d, got %0d", want.smp, sample);
            fail_count++;
          end
          if (modulator_out !== want.mod_out) begin
            $error("modulator_out: expected %0d, got %0d", want.mod_out, modulator_out);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_served != hold_req) begin
        hold_served++;
        stall_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("feedback_fm_oscillator verification failed");
    $finish;
  end

  // stimulus sequence
  initial begin
    for (int n = 0; n <= TBL; n++) cos_table[n] = cos_entry(n);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset step value: plain tones, both amplitude extremes, frequency saturation
    // both ways, extreme gains on a large stored feedback term
    push_word(0, 0, 0, 0);
    push_word(32767, 1000 * 256, 0, 0);
    push_word(-32768, 1000 * 256, 0, 0);
    push_word(16384, 440 * 256, 0, 0);
    push_word(16384, 440 * 256, 0, 0);
    push_word(32767, 8388607, 8388607, 0);
    push_word(32767, -8388608, -8388608, 0);
    push_word(-32768, 5000 * 256, 0, 32767);
    push_word(32767, 5000 * 256, 0, -32768);
    push_word(20000, 0, 3000 * 256, 4096);
    push_word(-1, -3000 * 256, 0, 4096);
    push_word(32767, 0, 0, 32767);
    settle();

    // largest step: the phase increment wraps
    write_step(20'hFFFFF);
    push_word(32767, 8388607, 0, 0);
    push_word(-32768, -8388608, 0, 0);
    push_word(1, 12345, -54321, -1);
    settle();

    // zero step: phase stands still
    write_step(20'h00000);
    push_word(32767, 1000 * 256, 0, 0);
    push_word(32767, 1000 * 256, 0, 0);
    settle();

    // highest sample rate step, no idling on either side
    write_step(20'd22369);
    no_idle = 1'b1;
    push_random(60);
    settle();
    no_idle = 1'b0;

    // lowest sample rate step with a long receiver hold while words wait to be sent
    write_step(20'd536870);
    hold_req++;
    push_random(150);
    settle();

    write_step(STEP_W'($urandom));
    push_random(150);
    settle();

    write_step(STEP_RESET);
    push_random(180);
    settle();

    if (expected_samples.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("feedback_fm_oscillator verification clean");
    end else begin
      $display("feedback_fm_oscillator verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/ffo_pkg.sv
design/ffo_mul.sv
design/ffo_rom.sv
design/feedback_fm_oscillator.sv
tb/tb_top.sv
